@@ rtl/i2cs_pkg.sv @@
// Package for the I2C master transfer sequencer: action and bus status codes,
// outcome codes, parameter defaults and the structs passed between modules.
// No dependencies; every other file of the block uses it by scoped names.
package i2cs_pkg;

    localparam int BufDepthDef = 16;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_START  = 2'd1,
        ACT_STATUS = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    // Bus status codes, status register shifted right by three.
    localparam logic [4:0] ST_START     = 5'd1;
    localparam logic [4:0] ST_REP_START = 5'd2;
    localparam logic [4:0] ST_SLA_W_ACK = 5'd3;
    localparam logic [4:0] ST_DATA_ACK  = 5'd5;
    localparam logic [4:0] ST_SLA_R_ACK = 5'd8;
    localparam logic [4:0] ST_RX_ACK    = 5'd10;
    localparam logic [4:0] ST_RX_NACK   = 5'd11;

    typedef enum logic [1:0] {
        OUT_NONE    = 2'd0,
        OUT_SUCCESS = 2'd1,
        OUT_FAILED  = 2'd2
    } t_outcome;

    // Buffer access request for one accepted item.
    typedef struct packed {
        logic       wr_en;
        logic [4:0] wr_pos;
        logic [7:0] wdata;
        logic       rd_en;
        logic [4:0] rd_pos;
    } t_mem_req;

    // Registered control part of a result; the byte fields come from the buffer.
    typedef struct packed {
        logic       tx_valid;
        logic       rd_valid;
        logic       ctl_enable;
        logic       ctl_busy;
        logic       ctl_clear_flag;
        logic       ctl_start;
        logic       ctl_stop;
        logic       ctl_ack;
        t_outcome   transfer_state;
        logic [4:0] error_code;
    } t_ctl_res;

    // Complete result item as delivered on the output channel.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       ctl_enable;
        logic       ctl_busy;
        logic       ctl_clear_flag;
        logic       ctl_start;
        logic       ctl_stop;
        logic       ctl_ack;
        logic [1:0] transfer_state;
        logic [4:0] error_code;
        logic [7:0] read_byte;
    } t_result;

endpackage

@@ rtl/i2c_master_transfer_sequencer_unit.sv @@
// Top level of the I2C master transfer sequencer: control, message buffer
// and output skid stage. Depends on i2cs_pkg, i2cs_ctrl, i2cs_buffer, i2cs_skid.
//
// Usage: software and the bus interface both present items on the input
// channel (i_in_valid / o_in_stall): buffer writes and reads, a transfer
// start, or a bus status event with the received byte. Each accepted item
// yields exactly one result item on the output channel (o_out_valid /
// i_out_stall) carrying the bus commands, the byte to send, the outcome
// and any byte read from the buffer.
// The result is registered first in the result register, where the buffer
// read is also registered, and then in the skid stage. Throughput is one
// item per cycle while the output channel does not stall; the state
// update and buffer access for an item complete in its accept cycle.
// Reset clears busy, the pointer, the length, the outcome and the error
// code; the buffer contents stay undefined until written.
// When the receiver stalls, the skid stage absorbs one further result and
// then the input channel stalls until results drain.
module i2c_master_transfer_sequencer_unit #(
    parameter int BUF_DEPTH = i2cs_pkg::BufDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [3:0] i_index,
    input  logic [7:0] i_data,
    input  logic [4:0] i_message_size,
    input  logic [4:0] i_bus_status,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_tx_valid,
    output logic       o_ctl_enable,
    output logic       o_ctl_busy,
    output logic       o_ctl_clear_flag,
    output logic       o_ctl_start,
    output logic       o_ctl_stop,
    output logic       o_ctl_ack,
    output logic [1:0] o_transfer_state,
    output logic [4:0] o_error_code,
    output logic [7:0] o_read_byte
);

    i2cs_pkg::t_mem_req w_req;
    i2cs_pkg::t_ctl_res w_ctl;
    i2cs_pkg::t_result  w_res;
    i2cs_pkg::t_result  w_out;
    logic               w_res_valid;
    logic               w_skid_stall;
    logic [7:0]         w_rdata;

    i2cs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_index        (i_index),
        .i_data         (i_data),
        .i_message_size (i_message_size),
        .i_bus_status   (i_bus_status),
        .o_req          (w_req),
        .o_res_valid    (w_res_valid),
        .i_res_stall    (w_skid_stall),
        .o_res          (w_ctl)
    );

    i2cs_buffer #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    // The buffer byte goes to whichever field the item asked for; the other is zero.
    always_comb begin
        w_res.tx_byte        = w_ctl.tx_valid ? w_rdata : 8'd0;
        w_res.tx_valid       = w_ctl.tx_valid;
        w_res.ctl_enable     = w_ctl.ctl_enable;
        w_res.ctl_busy       = w_ctl.ctl_busy;
        w_res.ctl_clear_flag = w_ctl.ctl_clear_flag;
        w_res.ctl_start      = w_ctl.ctl_start;
        w_res.ctl_stop       = w_ctl.ctl_stop;
        w_res.ctl_ack        = w_ctl.ctl_ack;
        w_res.transfer_state = w_ctl.transfer_state;
        w_res.error_code     = w_ctl.error_code;
        w_res.read_byte      = w_ctl.rd_valid ? w_rdata : 8'd0;
    end

    i2cs_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_stall (w_skid_stall),
        .i_data  (w_res),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_tx_byte        = w_out.tx_byte;
    assign o_tx_valid       = w_out.tx_valid;
    assign o_ctl_enable     = w_out.ctl_enable;
    assign o_ctl_busy       = w_out.ctl_busy;
    assign o_ctl_clear_flag = w_out.ctl_clear_flag;
    assign o_ctl_start      = w_out.ctl_start;
    assign o_ctl_stop       = w_out.ctl_stop;
    assign o_ctl_ack        = w_out.ctl_ack;
    assign o_transfer_state = w_out.transfer_state;
    assign o_error_code     = w_out.error_code;
    assign o_read_byte      = w_out.read_byte;

endmodule

@@ rtl/i2cs_buffer.sv @@
// Message buffer of the I2C sequencer: one write port and one registered
// read port. Positions past the depth are dropped on write and read as zero.
// Depends on i2cs_pkg for the request struct.
module i2cs_buffer #(
    parameter int BUF_DEPTH = i2cs_pkg::BufDepthDef
) (
    input  logic              i_clk,
    input  i2cs_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rdata;
    logic       w_wr_in_range;
    logic       w_rd_in_range;

    assign w_wr_in_range = ({27'd0, i_req.wr_pos} < 32'(BUF_DEPTH));
    assign w_rd_in_range = ({27'd0, i_req.rd_pos} < 32'(BUF_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && w_wr_in_range) begin
            r_mem[AW'(i_req.wr_pos)] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= w_rd_in_range ? r_mem[AW'(i_req.rd_pos)] : 8'd0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/i2cs_ctrl.sv @@
// Transfer control of the I2C sequencer: transfer state registers, the
// decision for each item and the result register for the control fields.
// Depends on i2cs_pkg; drives the buffer request.
module i2cs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_action,
    input  logic [3:0]          i_index,
    input  logic [7:0]          i_data,
    input  logic [4:0]          i_message_size,
    input  logic [4:0]          i_bus_status,
    output i2cs_pkg::t_mem_req  o_req,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output i2cs_pkg::t_ctl_res  o_res
);

    logic [4:0]          r_len, n_len;
    logic [4:0]          r_ptr, n_ptr;
    i2cs_pkg::t_outcome  r_outc, n_outc;
    logic [4:0]          r_fail, n_fail;
    logic                r_busy, n_busy;
    logic                r_v;
    i2cs_pkg::t_ctl_res  r_res, n_res;
    i2cs_pkg::t_mem_req  w_req;
    logic                w_accept;
    logic [4:0]          w_ptr;

    assign o_in_stall = r_v && i_res_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_len  = r_len;
        n_ptr  = r_ptr;
        n_outc = r_outc;
        n_fail = r_fail;
        n_busy = r_busy;
        w_ptr  = r_ptr;
        w_req  = '0;
        n_res  = '0;
        case (i2cs_pkg::t_action'(i_action))
            i2cs_pkg::ACT_WRITE: begin
                w_req.wr_en  = 1'b1;
                w_req.wr_pos = {1'b0, i_index};
                w_req.wdata  = i_data;
            end
            i2cs_pkg::ACT_READ: begin
                w_req.rd_en    = 1'b1;
                w_req.rd_pos   = {1'b0, i_index};
                n_res.rd_valid = 1'b1;
            end
            i2cs_pkg::ACT_START: begin
                if (!r_busy) begin
                    n_len                = i_message_size;
                    n_outc               = i2cs_pkg::OUT_NONE;
                    n_fail               = 5'd0;
                    n_busy               = 1'b1;
                    n_res.ctl_enable     = 1'b1;
                    n_res.ctl_clear_flag = 1'b1;
                    n_res.ctl_start      = 1'b1;
                end
            end
            i2cs_pkg::ACT_STATUS: begin
                if (r_busy) begin
                    n_res.ctl_enable = 1'b1;
                    case (i_bus_status)
                        i2cs_pkg::ST_START, i2cs_pkg::ST_REP_START,
                        i2cs_pkg::ST_SLA_W_ACK, i2cs_pkg::ST_DATA_ACK: begin
                            // A fresh START rewinds to the address byte.
                            if (i_bus_status == i2cs_pkg::ST_START ||
                                i_bus_status == i2cs_pkg::ST_REP_START) begin
                                w_ptr = 5'd0;
                            end
                            n_ptr = w_ptr;
                            if (w_ptr < r_len) begin
                                w_req.rd_en          = 1'b1;
                                w_req.rd_pos         = w_ptr;
                                n_res.tx_valid       = 1'b1;
                                n_res.ctl_clear_flag = 1'b1;
                                n_ptr                = 5'(w_ptr + 5'd1);
                            end else begin
                                n_outc               = i2cs_pkg::OUT_SUCCESS;
                                n_busy               = 1'b0;
                                n_res.ctl_clear_flag = 1'b1;
                                n_res.ctl_stop       = 1'b1;
                            end
                        end
                        i2cs_pkg::ST_RX_ACK, i2cs_pkg::ST_SLA_R_ACK: begin
                            if (i_bus_status == i2cs_pkg::ST_RX_ACK) begin
                                w_req.wr_en  = 1'b1;
                                w_req.wr_pos = r_ptr;
                                w_req.wdata  = i_data;
                                w_ptr        = 5'(r_ptr + 5'd1);
                            end
                            n_ptr                = w_ptr;
                            n_res.ctl_clear_flag = 1'b1;
                            // No ACK for the byte that will be the last one.
                            n_res.ctl_ack = (({1'b0, w_ptr} + 6'd1) < {1'b0, r_len});
                        end
                        i2cs_pkg::ST_RX_NACK: begin
                            w_req.wr_en          = 1'b1;
                            w_req.wr_pos         = r_ptr;
                            w_req.wdata          = i_data;
                            n_outc               = i2cs_pkg::OUT_SUCCESS;
                            n_busy               = 1'b0;
                            n_res.ctl_clear_flag = 1'b1;
                            n_res.ctl_stop       = 1'b1;
                        end
                        default: begin
                            n_outc = i2cs_pkg::OUT_FAILED;
                            n_fail = i_bus_status;
                            n_busy = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
        n_res.ctl_busy       = n_busy;
        n_res.transfer_state = n_outc;
        n_res.error_code     = n_fail;
    end

    always_comb begin
        o_req       = w_req;
        o_req.wr_en = w_req.wr_en && w_accept;
        o_req.rd_en = w_req.rd_en && w_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= 5'd0;
            r_ptr  <= 5'd0;
            r_outc <= i2cs_pkg::OUT_NONE;
            r_fail <= 5'd0;
            r_busy <= 1'b0;
            r_v    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_len  <= n_len;
                r_ptr  <= n_ptr;
                r_outc <= n_outc;
                r_fail <= n_fail;
                r_busy <= n_busy;
            end
            if (!o_in_stall) begin
                r_v <= w_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_v;
    assign o_res       = r_res;

    logic w_start_acc;
    assign w_start_acc = w_accept && (i2cs_pkg::t_action'(i_action) == i2cs_pkg::ACT_START);

    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> $past(w_start_acc))
        else $error("busy rose without an accepted start item");

    a_tx_not_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> !(r_res.tx_valid && r_res.ctl_stop))
        else $error("byte sent together with a stop request");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && r_res.ctl_start) |-> (r_res.ctl_busy && r_res.transfer_state == i2cs_pkg::OUT_NONE))
        else $error("start request without busy and cleared outcome");

    a_stop_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && r_res.ctl_stop) |-> (!r_res.ctl_busy && !r_busy))
        else $error("stop request while still busy");

endmodule

@@ rtl/i2cs_skid.sv @@
// Output skid stage of the I2C sequencer: a main and a spare register so
// that the upstream stall is registered. Depends on i2cs_pkg for t_result.
module i2cs_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  i2cs_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output i2cs_pkg::t_result o_data
);

    logic              r_m_v;
    logic              r_sp_v;
    i2cs_pkg::t_result r_m;
    i2cs_pkg::t_result r_sp;
    logic              w_take;

    assign o_stall = r_sp_v;
    assign w_take  = i_valid && !r_sp_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v  <= 1'b0;
            r_sp_v <= 1'b0;
        end else if (!r_m_v || !i_stall) begin
            r_m_v  <= r_sp_v || w_take;
            r_sp_v <= 1'b0;
        end else if (w_take) begin
            r_sp_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_m_v || !i_stall) begin
            r_m <= r_sp_v ? r_sp : i_data;
        end else if (w_take) begin
            r_sp <= i_data;
        end
    end

    assign o_valid = r_m_v;
    assign o_data  = r_m;

endmodule

@@ tb/i2cs_sequencer_checker.sv @@
// Checker for the I2C master transfer sequencer: watches both item channels,
// predicts every result from its own copy of the sequencer state and compares.
// Depends on i2cs_pkg for the action, status and outcome codes and t_result.
module i2cs_sequencer_checker #(
    parameter int BUF_DEPTH = i2cs_pkg::BufDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_action,
    input  logic [3:0] i_index,
    input  logic [7:0] i_data,
    input  logic [4:0] i_message_size,
    input  logic [4:0] i_bus_status,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_tx_byte,
    input  logic       i_tx_valid,
    input  logic       i_ctl_enable,
    input  logic       i_ctl_busy,
    input  logic       i_ctl_clear_flag,
    input  logic       i_ctl_start,
    input  logic       i_ctl_stop,
    input  logic       i_ctl_ack,
    input  logic [1:0] i_transfer_state,
    input  logic [4:0] i_error_code,
    input  logic [7:0] i_read_byte,
    output int         o_errors,
    output int         o_pending,
    output int         o_checked
);

    logic [7:0]         msg_buf [BUF_DEPTH];
    logic [4:0]         xfer_len;
    logic [4:0]         byte_pos;
    i2cs_pkg::t_outcome xfer_outcome;
    logic [4:0]         fault_code;
    logic               busy;

    i2cs_pkg::t_result  pending_results[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic logic [7:0] buf_at(input logic [4:0] pos);
        return (pos < BUF_DEPTH) ? msg_buf[pos] : 8'h00;
    endfunction

    // Applies one accepted item to the predicted state and returns its result.
    task automatic advance_sequencer(
        input  logic [1:0]         act,
        input  logic [3:0]         idx,
        input  logic [7:0]         dat,
        input  logic [4:0]         size,
        input  logic [4:0]         code,
        output i2cs_pkg::t_result  res
    );
        res = '0;
        case (act)
            i2cs_pkg::ACT_WRITE: begin
                if (idx < BUF_DEPTH) msg_buf[idx] = dat;
            end
            i2cs_pkg::ACT_READ: begin
                res.read_byte = buf_at({1'b0, idx});
            end
            i2cs_pkg::ACT_START: begin
                if (!busy) begin
                    xfer_len           = size;
                    xfer_outcome       = i2cs_pkg::OUT_NONE;
                    fault_code         = '0;
                    busy               = 1'b1;
                    res.ctl_enable     = 1'b1;
                    res.ctl_clear_flag = 1'b1;
                    res.ctl_start      = 1'b1;
                end
            end
            default: begin
                // Status events are ignored unless a transfer is running.
                if (busy) begin
                    res.ctl_enable = 1'b1;
                    case (code)
                        i2cs_pkg::ST_START, i2cs_pkg::ST_REP_START,
                        i2cs_pkg::ST_SLA_W_ACK, i2cs_pkg::ST_DATA_ACK: begin
                            if (code == i2cs_pkg::ST_START || code == i2cs_pkg::ST_REP_START)
                                byte_pos = '0;
                            if (byte_pos < xfer_len) begin
                                res.tx_byte        = buf_at(byte_pos);
                                res.tx_valid       = 1'b1;
                                res.ctl_clear_flag = 1'b1;
                                byte_pos           = byte_pos + 5'd1;
                            end else begin
                                xfer_outcome       = i2cs_pkg::OUT_SUCCESS;
                                busy               = 1'b0;
                                res.ctl_clear_flag = 1'b1;
                                res.ctl_stop       = 1'b1;
                            end
                        end
                        i2cs_pkg::ST_RX_ACK, i2cs_pkg::ST_SLA_R_ACK: begin
                            if (code == i2cs_pkg::ST_RX_ACK) begin
                                if (byte_pos < BUF_DEPTH) msg_buf[byte_pos] = dat;
                                byte_pos = byte_pos + 5'd1;
                            end
                            res.ctl_clear_flag = 1'b1;
                            res.ctl_ack        = (6'(byte_pos) + 6'd1) < 6'(xfer_len);
                        end
                        i2cs_pkg::ST_RX_NACK: begin
                            if (byte_pos < BUF_DEPTH) msg_buf[byte_pos] = dat;
                            xfer_outcome       = i2cs_pkg::OUT_SUCCESS;
                            busy               = 1'b0;
                            res.ctl_clear_flag = 1'b1;
                            res.ctl_stop       = 1'b1;
                        end
                        default: begin
                            xfer_outcome = i2cs_pkg::OUT_FAILED;
                            fault_code   = code;
                            busy         = 1'b0;
                        end
                    endcase
                end
            end
        endcase
        res.ctl_busy       = busy;
        res.transfer_state = xfer_outcome;
        res.error_code     = fault_code;
    endtask

    task automatic check_field(input string name, input logic [7:0] expv,
                               input logic [7:0] actv);
        if (actv !== expv) begin
            o_errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, expv, actv);
        end
    endtask

    always @(posedge i_clk) begin
        i2cs_pkg::t_result exp_res;
        i2cs_pkg::t_result new_res;
        if (!i_rst_n) begin
            xfer_len     = '0;
            byte_pos     = '0;
            xfer_outcome = i2cs_pkg::OUT_NONE;
            fault_code   = '0;
            busy         = 1'b0;
            pending_results.delete();
        end else begin
            // A result leaves before the item of this edge is predicted.
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pending_results.size() == 0) begin
                    o_errors++;
                    $display("%0t: result item arrived with nothing expected", $time);
                end else begin
                    exp_res = pending_results.pop_front();
                    o_checked++;
                    check_field("tx_byte", exp_res.tx_byte, i_tx_byte);
                    check_field("tx_valid", 8'(exp_res.tx_valid), 8'(i_tx_valid));
                    check_field("ctl_enable", 8'(exp_res.ctl_enable), 8'(i_ctl_enable));
                    check_field("ctl_busy", 8'(exp_res.ctl_busy), 8'(i_ctl_busy));
                    check_field("ctl_clear_flag", 8'(exp_res.ctl_clear_flag),
                                8'(i_ctl_clear_flag));
                    check_field("ctl_start", 8'(exp_res.ctl_start), 8'(i_ctl_start));
                    check_field("ctl_stop", 8'(exp_res.ctl_stop), 8'(i_ctl_stop));
                    check_field("ctl_ack", 8'(exp_res.ctl_ack), 8'(i_ctl_ack));
                    check_field("transfer_state", 8'(exp_res.transfer_state),
                                8'(i_transfer_state));
                    check_field("error_code", 8'(exp_res.error_code), 8'(i_error_code));
                    check_field("read_byte", exp_res.read_byte, i_read_byte);
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                advance_sequencer(i_action, i_index, i_data, i_message_size, i_bus_status,
                                  new_res);
                pending_results.push_back(new_res);
            end
        end
        o_pending = pending_results.size();
    end

endmodule

@@ tb/tb_i2c_master_transfer_sequencer_unit.sv @@
// Top of the sequencer testbench: clock, reset, item stimulus and receiver stalls.
// Depends on i2cs_pkg, the block i2c_master_transfer_sequencer_unit and the
// checker i2cs_sequencer_checker, which does all prediction and comparison.
module tb_i2c_master_transfer_sequencer_unit;

    localparam int WatchdogLimit = 2000;
    localparam int TargetItems   = 1400;
    localparam int HoldCycles    = 300;
    localparam int HoldAtResult  = 500;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [1:0] i_action       = '0;
    logic [3:0] i_index        = '0;
    logic [7:0] i_data         = '0;
    logic [4:0] i_message_size = '0;
    logic [4:0] i_bus_status   = '0;
    logic       i_out_stall    = 1'b0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_tx_byte;
    logic       o_tx_valid;
    logic       o_ctl_enable;
    logic       o_ctl_busy;
    logic       o_ctl_clear_flag;
    logic       o_ctl_start;
    logic       o_ctl_stop;
    logic       o_ctl_ack;
    logic [1:0] o_transfer_state;
    logic [4:0] o_error_code;
    logic [7:0] o_read_byte;

    int errors;
    int pending;
    int checked;

    int items_sent     = 0;
    int write_xfers    = 0;
    int read_xfers     = 0;
    int quiet_cycles   = 0;
    int rx_stall_left  = 0;
    int rx_hold_left   = 0;
    int rx_taken       = 0;
    bit rx_hold_done   = 1'b0;
    bit tx_gaps_on     = 1'b1;
    bit rx_gaps_on     = 1'b1;

    always #4 i_clk = ~i_clk;

    i2c_master_transfer_sequencer_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_index          (i_index),
        .i_data           (i_data),
        .i_message_size   (i_message_size),
        .i_bus_status     (i_bus_status),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_tx_byte        (o_tx_byte),
        .o_tx_valid       (o_tx_valid),
        .o_ctl_enable     (o_ctl_enable),
        .o_ctl_busy       (o_ctl_busy),
        .o_ctl_clear_flag (o_ctl_clear_flag),
        .o_ctl_start      (o_ctl_start),
        .o_ctl_stop       (o_ctl_stop),
        .o_ctl_ack        (o_ctl_ack),
        .o_transfer_state (o_transfer_state),
        .o_error_code     (o_error_code),
        .o_read_byte      (o_read_byte)
    );

    i2cs_sequencer_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_index          (i_index),
        .i_data           (i_data),
        .i_message_size   (i_message_size),
        .i_bus_status     (i_bus_status),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_tx_byte        (o_tx_byte),
        .i_tx_valid       (o_tx_valid),
        .i_ctl_enable     (o_ctl_enable),
        .i_ctl_busy       (o_ctl_busy),
        .i_ctl_clear_flag (o_ctl_clear_flag),
        .i_ctl_start      (o_ctl_start),
        .i_ctl_stop       (o_ctl_stop),
        .i_ctl_ack        (o_ctl_ack),
        .i_transfer_state (o_transfer_state),
        .i_error_code     (o_error_code),
        .i_read_byte      (o_read_byte),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    // Offers one item after a random gap and returns at the edge that accepts it.
    task automatic send_item(input i2cs_pkg::t_action act, input logic [3:0] idx,
                             input logic [7:0] dat, input logic [4:0] size,
                             input logic [4:0] code);
        int gap;
        if ($urandom_range(0, 49) == 0) tx_gaps_on = !tx_gaps_on;
        gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_index        <= idx;
        i_data         <= dat;
        i_message_size <= size;
        i_bus_status   <= code;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_sent++;
    endtask

    task automatic send_status(input logic [4:0] code);
        send_item(i2cs_pkg::ACT_STATUS, 4'($urandom), 8'($urandom),
                  5'($urandom_range(0, 16)), code);
    endtask

    task automatic send_start(input logic [4:0] size);
        send_item(i2cs_pkg::ACT_START, 4'($urandom), 8'($urandom), size, 5'($urandom));
    endtask

    function automatic logic [4:0] pick_fault_code();
        logic [4:0] c;
        do c = 5'($urandom);
        while (c == i2cs_pkg::ST_START || c == i2cs_pkg::ST_REP_START ||
               c == i2cs_pkg::ST_SLA_W_ACK || c == i2cs_pkg::ST_DATA_ACK ||
               c == i2cs_pkg::ST_SLA_R_ACK || c == i2cs_pkg::ST_RX_ACK ||
               c == i2cs_pkg::ST_RX_NACK);
        return c;
    endfunction

    // Receiver: a random stall after each result, and one long hold-off part way in.
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= (rx_hold_left != 0);
        end else if (o_out_valid === 1'b1 && !i_out_stall) begin
            rx_taken++;
            if (rx_taken == HoldAtResult && !rx_hold_done) begin
                rx_hold_done = 1'b1;
                rx_hold_left = HoldCycles;
                i_out_stall <= 1'b1;
            end else begin
                if ($urandom_range(0, 39) == 0) rx_gaps_on = !rx_gaps_on;
                rx_stall_left = rx_gaps_on ? $urandom_range(0, 7) : 0;
                i_out_stall <= (rx_stall_left != 0);
            end
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_stall <= (rx_stall_left != 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int  n;
        int  reps;
        int  k;
        int  pick;
        bit  aborted;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the whole buffer first, so that no later access sees an unwritten entry.
        for (k = 0; k < 16; k++)
            send_item(i2cs_pkg::ACT_WRITE, 4'(k),
                      (k == 0) ? 8'h00 : (k == 15) ? 8'hFF : 8'($urandom),
                      5'($urandom_range(0, 16)), 5'($urandom));
        send_item(i2cs_pkg::ACT_READ, 4'd15, 8'hFF, 5'd16, 5'd31);
        send_status(i2cs_pkg::ST_START);              // idle, so ignored
        send_start(5'd0);
        send_start(5'd16);                            // already busy, so ignored
        send_status(i2cs_pkg::ST_START);              // empty message stops at once
        send_start(5'd0);
        send_status(i2cs_pkg::ST_SLA_R_ACK);          // no ACK on an empty read
        send_item(i2cs_pkg::ACT_STATUS, 4'd0, 8'hFF, 5'd0, i2cs_pkg::ST_RX_NACK);
        send_start(5'd16);
        send_status(5'd31);                           // unknown code aborts

        while (items_sent < TargetItems) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                reps = $urandom_range(0, 3);
                repeat (reps)
                    send_item(i2cs_pkg::ACT_WRITE, 4'($urandom), 8'($urandom),
                              5'($urandom_range(0, 16)), 5'($urandom));
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
                send_start(5'(n));
                send_status(($urandom_range(0, 3) == 0) ? i2cs_pkg::ST_REP_START
                                                        : i2cs_pkg::ST_START);
                aborted = 1'b0;
                for (k = 0; k < n && !aborted; k++) begin
                    if ($urandom_range(0, 39) == 0) begin
                        send_status(pick_fault_code());
                        aborted = 1'b1;
                    end else if ($urandom_range(0, 29) == 0) begin
                        // A repeated START sends the address byte again.
                        send_status(i2cs_pkg::ST_REP_START);
                        k = -1;
                    end else begin
                        send_status((k == 0) ? i2cs_pkg::ST_SLA_W_ACK : i2cs_pkg::ST_DATA_ACK);
                    end
                end
                write_xfers++;
            end else if (pick < 70) begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 8);
                send_start(5'(n));
                send_status(i2cs_pkg::ST_START);
                if (n != 0) begin
                    send_status(i2cs_pkg::ST_SLA_R_ACK);
                    // Now and then a read long enough to run the byte counter round.
                    reps = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 40)
                                                        : ((n >= 2) ? n - 2 : 0);
                    aborted = 1'b0;
                    for (k = 0; k < reps && !aborted; k++) begin
                        if ($urandom_range(0, 39) == 0) begin
                            send_status(pick_fault_code());
                            aborted = 1'b1;
                        end else begin
                            send_status(i2cs_pkg::ST_RX_ACK);
                        end
                    end
                    if (!aborted) send_status(i2cs_pkg::ST_RX_NACK);
                end
                read_xfers++;
            end else if (pick < 85) begin
                reps = $urandom_range(1, 4);
                repeat (reps)
                    send_item($urandom_range(0, 1) ? i2cs_pkg::ACT_WRITE : i2cs_pkg::ACT_READ,
                              4'($urandom), 8'($urandom), 5'($urandom_range(0, 16)),
                              5'($urandom));
            end else begin
                reps = $urandom_range(1, 3);
                repeat (reps)
                    send_item(i2cs_pkg::t_action'($urandom_range(0, 3)), 4'($urandom),
                              8'($urandom), 5'($urandom_range(0, 16)), 5'($urandom));
            end
        end
        i_in_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d items in %0d write and %0d read transfers plus buffer and noise items,",
                 items_sent, write_xfers, read_xfers);
        $display("checked %0d results, with one receiver hold-off of %0d cycles.",
                 checked, HoldCycles);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
